/* rtl/core/pli_pkg.sv */
// Package for the piecewise linear interpolator: item structs and mode codes.
// No dependencies.
`default_nettype none
package pli_pkg;
  localparam int unsigned ValW = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned SizeW = 5;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_EVAL  = 1'b1
  } mode_e;

  typedef struct packed {
    logic                   mode;
    logic [IdxW-1:0]        point_index;
    logic signed [ValW-1:0] point_x;
    logic signed [ValW-1:0] point_y;
    logic signed [ValW-1:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] result_y;
    logic                   in_segment;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

/* rtl/core/pli_cell.sv */
// One breakpoint cell of the point chain: holds x/y and passes them to its
// neighbor while the chain rotates. No dependencies.
`default_nettype none
module pli_cell #(
  parameter int unsigned VW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          load_i,
  input  wire logic          shift_i,
  input  wire logic [VW-1:0] load_x_i,
  input  wire logic [VW-1:0] load_y_i,
  input  wire logic [VW-1:0] prev_x_i,
  input  wire logic [VW-1:0] prev_y_i,
  output logic      [VW-1:0] x_o,
  output logic      [VW-1:0] y_o
);
  logic [VW-1:0] x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= load_x_i;
      y_q <= load_y_i;
    end else if (shift_i) begin
      x_q <= prev_x_i;
      y_q <= prev_y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
endmodule
`default_nettype wire

/* rtl/core/pli_divider.sv */
// Restoring unsigned divider, one quotient bit a cycle: floor(num / den).
// No dependencies.
`default_nettype none
module pli_divider #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic      [NW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NW + 1);
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW:0]     rem_q, rem_d;
  logic [DW-1:0]   den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DW:0]     trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[DW-1:0], quo_q[NW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CntW'(NW);
      run_d = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

/* rtl/core/piecewise_linear_interpolator_unit.sv */
// Top level of the piecewise linear interpolator: cell chain, segment scan,
// single divider. Depends on pli_pkg, pli_cell, pli_divider.
`default_nettype none
// Usage:
//   Items enter on start/in_item_i when busy is low. A write item stores
//   one breakpoint and gives no result. An evaluate item rotates the
//   breakpoint chain one cell a cycle past a comparator at cells 0 and 1,
//   then runs a restoring division when a segment with nonzero width is
//   found. The chain always makes a full rotation so it returns to its
//   written order. One item at a time.
//   The result is shown for one cycle on out_item_o with out_valid_o; the
//   receiver cannot stall it.
//   table_size is written through cfg_valid_i/cfg_ready_o (always ready) and
//   is clamped to MAX_POINTS where used. Reset clears table_size and control state; the
//   breakpoints are undefined until written.
module piecewise_linear_interpolator_unit #(
  parameter int unsigned MAX_POINTS  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire pli_pkg::in_item_t   in_item_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [pli_pkg::SizeW-1:0] cfg_data_i,
  output logic                     out_valid_o,
  output pli_pkg::out_item_t       out_item_o
);
  localparam int unsigned VW  = pli_pkg::ValW;
  localparam int unsigned NW  = 2 * VW + 2;
  localparam int unsigned DW  = VW + 1;
  localparam int unsigned PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);

  pli_pkg::state_e state_q, state_d;
  logic [CW-1:0]  size_q, n_eff, step_q, step_d;
  logic           found_q, found_d, neg_q, neg_d;
  logic [VW-1:0]  query_q, base_q, base_d, res_q, res_d;
  logic           outv_q, outv_d;
  logic           shift, div_start, div_done;
  logic [NW-1:0]  div_num, div_quo;
  logic [DW-1:0]  div_den;
  logic [VW-1:0]  cx [MAX_POINTS];
  logic [VW-1:0]  cy [MAX_POINTS];

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != pli_pkg::ST_IDLE);
  assign n_eff = (size_q > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : size_q;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    logic ld;
    assign ld = start && !busy && (in_item_i.mode == pli_pkg::MODE_WRITE) &&
                ({{(32-pli_pkg::IdxW){1'b0}}, in_item_i.point_index} == g);
    pli_cell #(.VW(VW)) u_cell (
      .clk_i, .load_i(ld), .shift_i(shift),
      .load_x_i(VW'(in_item_i.point_x)), .load_y_i(VW'(in_item_i.point_y)),
      .prev_x_i(cx[(g + 1) % MAX_POINTS]), .prev_y_i(cy[(g + 1) % MAX_POINTS]),
      .x_o(cx[g]), .y_o(cy[g])
    );
  end

  // segment compare on cells 0 and 1
  logic signed [VW-1:0] xa, xb, q;
  logic                 swp, hit;
  logic signed [VW:0]   dy, ofs, dom;
  logic [VW-1:0]        bs, ot;
  always_comb begin
    xa  = cx[0];
    xb  = cx[1 % MAX_POINTS];
    q   = query_q;
    swp = xa > xb;
    hit = swp ? (q >= xb && q <= xa) : (q >= xa && q <= xb);
    bs  = swp ? cy[1 % MAX_POINTS] : cy[0];
    ot  = swp ? cy[0] : cy[1 % MAX_POINTS];
    dy  = $signed({ot[VW-1], ot}) - $signed({bs[VW-1], bs});
    ofs = $signed({q[VW-1], q}) - (swp ? $signed({xb[VW-1], xb}) : $signed({xa[VW-1], xa}));
    dom = swp ? ($signed({xa[VW-1], xa}) - $signed({xb[VW-1], xb}))
              : ($signed({xb[VW-1], xb}) - $signed({xa[VW-1], xa}));
  end

  // magnitude product registered before the divider
  logic [NW-1:0] prod_q;
  logic [DW-1:0] dom_q;
  logic [VW:0]   ady;
  assign ady = dy[VW] ? (VW+1)'(-dy) : dy;

  pli_divider #(.NW(NW), .DW(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );
  assign div_num = prod_q;
  assign div_den = dom_q;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    found_d   = found_q;
    neg_d     = neg_q;
    base_d    = base_q;
    res_d     = res_q;
    outv_d    = 1'b0;
    shift     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      pli_pkg::ST_IDLE: begin
        if (start && in_item_i.mode == pli_pkg::MODE_EVAL) begin
          state_d = pli_pkg::ST_SCAN;
          step_d  = '0;
          found_d = 1'b0;
          res_d   = (n_eff == '0) ? '0 : cy[n_eff[PW-1:0] - 1'b1];
        end
      end
      pli_pkg::ST_SCAN: begin
        // rotate full circle; test the pair at cells 0/1 while in range
        shift  = 1'b1;
        step_d = step_q + 1'b1;
        if (!found_q && (step_q + 1'b1 < n_eff) && hit) begin
          found_d = 1'b1;
          neg_d   = dy[VW];
          base_d  = bs;
          res_d   = bs;
        end
        if (step_q == CW'(MAX_POINTS - 1)) begin
          if (found_d && dom_q != '0 && found_q) state_d = pli_pkg::ST_DIV;
          else if (found_d && !found_q && dom != '0) state_d = pli_pkg::ST_DIV;
          else state_d = pli_pkg::ST_DONE;
        end
      end
      pli_pkg::ST_DIV: begin
        // the scan leaves the step count at MAX_POINTS: kick the divider once
        if (step_q == CW'(MAX_POINTS)) begin
          div_start = 1'b1;
          step_d    = '0;
        end
        if (div_done) begin
          res_d   = neg_q ? base_q - div_quo[VW-1:0] : base_q + div_quo[VW-1:0];
          state_d = pli_pkg::ST_DONE;
        end
      end
      pli_pkg::ST_DONE: begin
        outv_d  = 1'b1;
        state_d = pli_pkg::ST_IDLE;
      end
      default: state_d = pli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pli_pkg::ST_IDLE;
      size_q  <= '0;
      step_q  <= '0;
      found_q <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      found_q <= found_d;
      outv_q  <= outv_d;
      if (cfg_valid_i) size_q <= CW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    base_q <= base_d;
    res_q  <= res_d;
    if (start && !busy) query_q <= VW'(in_item_i.query_x);
    if (state_q == pli_pkg::ST_SCAN && !found_q && found_d) begin
      prod_q <= NW'(ady) * NW'(ofs);
      dom_q  <= DW'(dom);
    end
  end

  assign out_valid_o           = outv_q;
  assign out_item_o.result_y   = res_q;
  assign out_item_o.in_segment = found_q;
endmodule
`default_nettype wire

/* rtl/core/pli_checker.sv */
// Port-level checks for the interpolator, bound to the top level.
// Depends on piecewise_linear_interpolator_unit ports.
`default_nettype none
module pli_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid_o
);
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o) else $error("double result");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy)) else $error("result while idle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy) else $error("busy with result");
endmodule

bind piecewise_linear_interpolator_unit pli_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .out_valid_o
);
`default_nettype wire
